// ----- src/bfa_pkg.sv -----
// ============================================================================
// Best-fit block allocator package
// Shared widths, codes and beat types for the allocator and its submodules.
// ============================================================================
package bfa_pkg;

    localparam int OFS_W  = 16;
    localparam int POOL_W = 17;
    localparam int KEY_W  = OFS_W + 1;

    localparam int MAX_BLOCKS_DEF   = 16;
    localparam int HEADER_BYTES_DEF = 16;

    localparam logic [POOL_W-1:0] POOL_LOW  = 17'd32;
    localparam logic [POOL_W-1:0] POOL_HIGH = 17'd65536;

    // Configuration port: 32-bit data; only the pool size register is mapped.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_POOL_SIZE = 1'b0;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_IGNORED = 2'd2,
        ST_NOSPLIT = 2'd3
    } t_status;

    // What one pass over the block table looks for.
    typedef enum logic [1:0] {
        OP_FIT  = 2'd0,
        OP_HIT  = 2'd1,
        OP_NEXT = 2'd2,
        OP_PREV = 2'd3
    } t_scan_op;

    typedef struct packed {
        t_cmd              command;
        logic [OFS_W-1:0]  request_bytes;
        logic [OFS_W-1:0]  payload_offset_in;
    } t_item;

    typedef struct packed {
        logic [OFS_W-1:0]  payload_offset;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic [OFS_W-1:0]  start;
        logic [OFS_W-1:0]  bytes;
        logic              valid;
        logic              used;
    } t_entry;

    typedef struct packed {
        logic              start_we;
        logic [OFS_W-1:0]  start;
        logic              bytes_we;
        logic [OFS_W-1:0]  bytes;
        logic              valid_we;
        logic              valid_val;
        logic              used_we;
        logic              used_val;
    } t_tbl_wr;

endpackage

// ----- src/bfa_cfg.sv -----
// ============================================================================
// Allocator configuration register
// Holds the pool size, saturates written values and flags a table reset.
// ============================================================================
module bfa_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfa_pkg::APB_AW-1:0]    paddr,
    input  logic [bfa_pkg::APB_DW-1:0]    pwdata,
    output logic [bfa_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output logic [bfa_pkg::POOL_W-1:0]    o_pool,
    output logic                          o_init
);
    import bfa_pkg::*;

    logic [POOL_W-1:0] r_pool;
    logic [POOL_W-1:0] n_pool;
    logic [POOL_W-1:0] w_raw;
    logic              w_sel;

    assign w_sel  = (paddr[APB_AW-1:2] == REG_POOL_SIZE);
    assign w_raw  = pwdata[POOL_W-1:0];
    assign o_init = psel & penable & pwrite & w_sel;
    assign pready = 1'b1;
    assign prdata = w_sel ? APB_DW'(r_pool) : '0;
    assign o_pool = r_pool;

    always_comb begin
        priority if (w_raw < POOL_LOW) begin
            n_pool = POOL_LOW;
        end else if (w_raw > POOL_HIGH) begin
            n_pool = POOL_HIGH;
        end else begin
            n_pool = w_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= POOL_HIGH;
        end else if (o_init) begin
            r_pool <= n_pool;
        end
    end

endmodule

// ----- src/bfa_table.sv -----
// ============================================================================
// Allocator block table
// Start and size memories with registered reads, plus valid and used flags.
// ============================================================================
module bfa_table #(
    parameter int MAX_BLOCKS   = bfa_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_init,
    input  logic [bfa_pkg::POOL_W-1:0]      i_pool,
    input  logic                            i_rd_en,
    input  logic [$clog2(MAX_BLOCKS)-1:0]   i_rd_addr,
    output bfa_pkg::t_entry                 o_entry,
    input  logic [$clog2(MAX_BLOCKS)-1:0]   i_wr_addr,
    input  bfa_pkg::t_tbl_wr                i_wr
);
    import bfa_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam logic [POOL_W-1:0] HDR_P = POOL_W'(HEADER_BYTES);

    logic [OFS_W-1:0]      r_mem_start [MAX_BLOCKS];
    logic [OFS_W-1:0]      r_mem_bytes [MAX_BLOCKS];
    logic [OFS_W-1:0]      r_rd_start;
    logic [OFS_W-1:0]      r_rd_bytes;
    logic [AW-1:0]         r_rd_addr;
    logic                  r_rd_zs;
    logic                  r_rd_zb;
    logic [MAX_BLOCKS-1:0] r_valid;
    logic [MAX_BLOCKS-1:0] r_used;
    logic                  r_fresh_start;
    logic                  r_fresh_bytes;
    logic [POOL_W-1:0]     w_pool_less;
    logic [OFS_W-1:0]      w_rst_bytes;

    // Entry 0 reads as the initial free block until each field is written.
    assign w_pool_less = i_pool - HDR_P;
    assign w_rst_bytes = (i_pool > HDR_P) ? w_pool_less[OFS_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (i_wr.start_we) begin
            r_mem_start[i_wr_addr] <= i_wr.start;
        end
        if (i_wr.bytes_we) begin
            r_mem_bytes[i_wr_addr] <= i_wr.bytes;
        end
        if (i_rd_en) begin
            r_rd_start <= r_mem_start[i_rd_addr];
            r_rd_bytes <= r_mem_bytes[i_rd_addr];
            r_rd_addr  <= i_rd_addr;
            r_rd_zs    <= r_fresh_start && (i_rd_addr == '0);
            r_rd_zb    <= r_fresh_bytes && (i_rd_addr == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_valid       <= MAX_BLOCKS'(1);
            r_used        <= '0;
            r_fresh_start <= 1'b1;
            r_fresh_bytes <= 1'b1;
        end else begin
            if (i_wr.valid_we) begin
                r_valid[i_wr_addr] <= i_wr.valid_val;
            end
            if (i_wr.used_we) begin
                r_used[i_wr_addr] <= i_wr.used_val;
            end
            if (i_wr.start_we && (i_wr_addr == '0)) begin
                r_fresh_start <= 1'b0;
            end
            if (i_wr.bytes_we && (i_wr_addr == '0)) begin
                r_fresh_bytes <= 1'b0;
            end
        end
    end

    always_comb begin
        o_entry.start = r_rd_zs ? '0 : r_rd_start;
        o_entry.bytes = r_rd_zb ? w_rst_bytes : r_rd_bytes;
        o_entry.valid = r_valid[r_rd_addr];
        o_entry.used  = r_used[r_rd_addr];
    end

endmodule

// ----- src/bfa_match.sv -----
// ============================================================================
// Allocator entry compare unit
// Shared by all passes: adder and equality check, plus size checks for fit.
// ============================================================================
module bfa_match #(
    parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF
) (
    input  bfa_pkg::t_scan_op               i_op,
    input  bfa_pkg::t_entry                 i_entry,
    input  logic [bfa_pkg::KEY_W-1:0]       i_key,
    input  logic [bfa_pkg::OFS_W-1:0]       i_best_bytes,
    input  logic                            i_have_best,
    input  logic                            i_is_hit,
    output logic                            o_match
);
    import bfa_pkg::*;

    localparam int SUM_W = OFS_W + 2;
    localparam logic [SUM_W-1:0] HDR_S = SUM_W'(HEADER_BYTES);

    logic [SUM_W-1:0] w_sum;
    logic             w_eq;
    logic             w_free;

    // Start, optionally plus header and payload size, against the key.
    assign w_sum = SUM_W'(i_entry.start)
                 + ((i_op == OP_PREV) ? SUM_W'(i_entry.bytes) : '0)
                 + ((i_op == OP_HIT || i_op == OP_PREV) ? HDR_S : '0);
    assign w_eq   = (w_sum == SUM_W'(i_key));
    assign w_free = i_entry.valid & ~i_entry.used;

    always_comb begin
        unique case (i_op)
            OP_FIT: begin
                o_match = w_free && (i_entry.bytes >= i_key[OFS_W-1:0])
                        && (!i_have_best || (i_entry.bytes < i_best_bytes));
            end
            OP_HIT: begin
                o_match = i_entry.valid && i_entry.used && w_eq;
            end
            default: begin
                o_match = w_free && !i_is_hit && w_eq;
            end
        endcase
    end

endmodule

// ----- src/best_fit_block_allocator_unit.sv -----
// ============================================================================
// Best-fit block allocator
// Sequencer that serves allocate and free commands over a block table.
// ============================================================================
// A command beat is taken on a rising edge with start high and busy low; busy
// then stays high until the command is finished (a null free never raises it).
// Each command gives exactly one result beat: o_valid is high for one cycle
// with o_result, and the receiver cannot stall it, so no result is ever held
// back. An allocate makes one pass over the table with the shared compare
// unit, one entry per cycle; its result beat is registered from the allocate
// state, or from the split state that follows it when the block is split. A
// free makes up to three passes (hit, following neighbor, preceding neighbor);
// a null free answers in the cycle after it is taken.
// The pass length is set by the single read port of the table memories. A new
// command may be taken in the cycle that shows the previous result.
// Reset, and any write of pool_size over the APB port, returns the table to
// one free block covering the pool less one header; no clearing pass is
// needed. The user must write pool size only while the block is idle; the
// block itself does not enforce this.
// ============================================================================
module best_fit_block_allocator_unit #(
    parameter int MAX_BLOCKS   = bfa_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bfa_pkg::t_item                i_item,
    output logic                          o_valid,
    output bfa_pkg::t_result              o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfa_pkg::APB_AW-1:0]    paddr,
    input  logic [bfa_pkg::APB_DW-1:0]    pwdata,
    output logic [bfa_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import bfa_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [OFS_W-1:0] HDR   = OFS_W'(HEADER_BYTES);
    localparam logic [CW-1:0]    N_CNT = CW'(MAX_BLOCKS);
    localparam logic [AW-1:0]    LAST  = AW'(MAX_BLOCKS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC,
        S_SPLIT,
        S_HIT_DEC,
        S_NEXT_DEC,
        S_NEXT_WR,
        S_PREV_DEC,
        S_PREV_WR
    } t_state;

    t_state            r_state, n_state;
    t_scan_op          r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [OFS_W-1:0]  r_req, n_req;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_data_v, n_data_v;
    logic [AW-1:0]     r_data_idx, n_data_idx;
    logic              r_found, n_found;
    logic [AW-1:0]     r_sel_idx, n_sel_idx;
    logic [OFS_W-1:0]  r_sel_start, n_sel_start;
    logic [OFS_W-1:0]  r_sel_bytes, n_sel_bytes;
    logic              r_slot_found, n_slot_found;
    logic [AW-1:0]     r_slot, n_slot;
    logic [AW-1:0]     r_hit, n_hit;
    logic [OFS_W-1:0]  r_hit_start, n_hit_start;
    logic [OFS_W-1:0]  r_hit_bytes, n_hit_bytes;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic [POOL_W-1:0] w_pool;
    logic              w_init;
    logic              w_rd_en;
    t_entry            w_entry;
    logic              w_match;
    logic [AW-1:0]     w_wr_addr;
    t_tbl_wr           w_wr;
    logic [OFS_W-1:0]  w_gap;
    logic              w_split;

    bfa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_pool  (w_pool),
        .o_init  (w_init)
    );

    bfa_table #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_init    (w_init),
        .i_pool    (w_pool),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_entry   (w_entry),
        .i_wr_addr (w_wr_addr),
        .i_wr      (w_wr)
    );

    bfa_match #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_match (
        .i_op         (r_op),
        .i_entry      (w_entry),
        .i_key        (r_key),
        .i_best_bytes (r_sel_bytes),
        .i_have_best  (r_found),
        .i_is_hit     (r_data_idx == r_hit),
        .o_match      (w_match)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign w_rd_en  = (r_state == S_SCAN) && (r_idx < N_CNT);
    assign w_gap    = r_sel_bytes - r_req;
    assign w_split  = (w_gap > HDR);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_req        = r_req;
        n_idx        = r_idx;
        n_data_v     = 1'b0;
        n_data_idx   = r_data_idx;
        n_found      = r_found;
        n_sel_idx    = r_sel_idx;
        n_sel_start  = r_sel_start;
        n_sel_bytes  = r_sel_bytes;
        n_slot_found = r_slot_found;
        n_slot       = r_slot;
        n_hit        = r_hit;
        n_hit_start  = r_hit_start;
        n_hit_bytes  = r_hit_bytes;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        w_wr_addr    = r_sel_idx;
        w_wr         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_item.request_bytes;
                    if (i_item.command == CMD_ALLOC) begin
                        n_op         = OP_FIT;
                        n_key        = KEY_W'(i_item.request_bytes);
                        n_idx        = '0;
                        n_found      = 1'b0;
                        n_slot_found = 1'b0;
                        n_state      = S_SCAN;
                    end else if (i_item.payload_offset_in == '0) begin
                        n_out_valid          = 1'b1;
                        n_out.payload_offset = '0;
                        n_out.status         = ST_IGNORED;
                    end else begin
                        n_op    = OP_HIT;
                        n_key   = KEY_W'(i_item.payload_offset_in);
                        n_idx   = '0;
                        n_found = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Reads are issued one entry a cycle; the data returns in the
                // next cycle together with its index.
                if (w_rd_en) begin
                    n_idx      = r_idx + CW'(1);
                    n_data_v   = 1'b1;
                    n_data_idx = r_idx[AW-1:0];
                end
                if (r_data_v) begin
                    if (w_match && (r_op == OP_FIT || !r_found)) begin
                        n_found     = 1'b1;
                        n_sel_idx   = r_data_idx;
                        n_sel_start = w_entry.start;
                        n_sel_bytes = w_entry.bytes;
                    end
                    if (r_op == OP_FIT && !w_entry.valid && !r_slot_found) begin
                        n_slot_found = 1'b1;
                        n_slot       = r_data_idx;
                    end
                    if (r_data_idx == LAST) begin
                        unique case (r_op)
                            OP_FIT:  n_state = S_ALLOC;
                            OP_HIT:  n_state = S_HIT_DEC;
                            OP_NEXT: n_state = S_NEXT_DEC;
                            OP_PREV: n_state = S_PREV_DEC;
                        endcase
                    end
                end
            end

            S_ALLOC: begin
                if (!r_found) begin
                    n_out_valid          = 1'b1;
                    n_out.payload_offset = '0;
                    n_out.status         = ST_NO_FIT;
                    n_state              = S_IDLE;
                end else begin
                    w_wr.used_we  = 1'b1;
                    w_wr.used_val = 1'b1;
                    if (w_split && r_slot_found) begin
                        w_wr.bytes_we = 1'b1;
                        w_wr.bytes    = r_req;
                        n_state       = S_SPLIT;
                    end else begin
                        n_out_valid          = 1'b1;
                        n_out.payload_offset = r_sel_start + HDR;
                        n_out.status         = w_split ? ST_NOSPLIT : ST_DONE;
                        n_state              = S_IDLE;
                    end
                end
            end

            S_SPLIT: begin
                // The rest of the block becomes a new free entry.
                w_wr_addr            = r_slot;
                w_wr.start_we        = 1'b1;
                w_wr.start           = r_sel_start + HDR + r_req;
                w_wr.bytes_we        = 1'b1;
                w_wr.bytes           = w_gap - HDR;
                w_wr.valid_we        = 1'b1;
                w_wr.valid_val       = 1'b1;
                w_wr.used_we         = 1'b1;
                w_wr.used_val        = 1'b0;
                n_out_valid          = 1'b1;
                n_out.payload_offset = r_sel_start + HDR;
                n_out.status         = ST_DONE;
                n_state              = S_IDLE;
            end

            S_HIT_DEC: begin
                if (!r_found) begin
                    n_out_valid          = 1'b1;
                    n_out.payload_offset = '0;
                    n_out.status         = ST_IGNORED;
                    n_state              = S_IDLE;
                end else begin
                    w_wr.used_we  = 1'b1;
                    w_wr.used_val = 1'b0;
                    n_hit         = r_sel_idx;
                    n_hit_start   = r_sel_start;
                    n_hit_bytes   = r_sel_bytes;
                    n_op          = OP_NEXT;
                    n_key         = KEY_W'(r_sel_start) + KEY_W'(HDR) + KEY_W'(r_sel_bytes);
                    n_idx         = '0;
                    n_found       = 1'b0;
                    n_state       = S_SCAN;
                end
            end

            S_NEXT_DEC: begin
                if (r_found) begin
                    w_wr.valid_we  = 1'b1;
                    w_wr.valid_val = 1'b0;
                    n_hit_bytes    = r_hit_bytes + HDR + r_sel_bytes;
                    n_state        = S_NEXT_WR;
                end else begin
                    n_op    = OP_PREV;
                    n_key   = KEY_W'(r_hit_start);
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end

            S_NEXT_WR: begin
                w_wr_addr     = r_hit;
                w_wr.bytes_we = 1'b1;
                w_wr.bytes    = r_hit_bytes;
                n_op          = OP_PREV;
                n_key         = KEY_W'(r_hit_start);
                n_idx         = '0;
                n_found       = 1'b0;
                n_state       = S_SCAN;
            end

            S_PREV_DEC: begin
                if (r_found) begin
                    w_wr.bytes_we = 1'b1;
                    w_wr.bytes    = r_sel_bytes + HDR + r_hit_bytes;
                    n_state       = S_PREV_WR;
                end else begin
                    n_out_valid          = 1'b1;
                    n_out.payload_offset = '0;
                    n_out.status         = ST_DONE;
                    n_state              = S_IDLE;
                end
            end

            S_PREV_WR: begin
                w_wr_addr            = r_hit;
                w_wr.valid_we        = 1'b1;
                w_wr.valid_val       = 1'b0;
                n_out_valid          = 1'b1;
                n_out.payload_offset = '0;
                n_out.status         = ST_DONE;
                n_state              = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_data_v     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_found      <= 1'b0;
            r_slot_found <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state      <= n_state;
            r_data_v     <= n_data_v;
            r_out_valid  <= n_out_valid;
            r_found      <= n_found;
            r_slot_found <= n_slot_found;
            r_idx        <= n_idx;
        end
        r_op        <= n_op;
        r_key       <= n_key;
        r_req       <= n_req;
        r_data_idx  <= n_data_idx;
        r_sel_idx   <= n_sel_idx;
        r_sel_start <= n_sel_start;
        r_sel_bytes <= n_sel_bytes;
        r_slot      <= n_slot;
        r_hit       <= n_hit;
        r_hit_start <= n_hit_start;
        r_hit_bytes <= n_hit_bytes;
        r_out       <= n_out;
    end

endmodule

// ----- bench/best_fit_block_allocator_unit_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Best-fit allocator checker
// Watches the command, result and APB channels of the allocator. It keeps its
// own copy of the block table and pool size, predicts the result beat of every
// accepted command, and compares each result beat field by field.
// ============================================================================
module best_fit_block_allocator_unit_checker #(
    parameter int MAX_BLOCKS   = bfa_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  bfa_pkg::t_item                i_item,
    input  logic                          i_valid,
    input  bfa_pkg::t_result              i_result,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [bfa_pkg::APB_AW-1:0]    i_paddr,
    input  logic [bfa_pkg::APB_DW-1:0]    i_pwdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import bfa_pkg::*;

    int unsigned pool_bytes;
    int unsigned blk_start [MAX_BLOCKS];
    int unsigned blk_bytes [MAX_BLOCKS];
    bit          blk_used  [MAX_BLOCKS];
    bit          blk_valid [MAX_BLOCKS];
    t_result     grant_expect [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report(input string msg);
        $display("%0t ns: allocator mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    // One free block covering the pool less one header.
    function automatic void init_table();
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            blk_start[i] = 0;
            blk_bytes[i] = 0;
            blk_used[i]  = 1'b0;
            blk_valid[i] = 1'b0;
        end
        blk_valid[0] = 1'b1;
        blk_bytes[0] = (pool_bytes > HEADER_BYTES) ? pool_bytes - HEADER_BYTES : 0;
    endfunction

    function automatic int unsigned block_end(input int idx);
        return blk_start[idx] + HEADER_BYTES + blk_bytes[idx];
    endfunction

    function automatic t_result predict_alloc(input int unsigned req);
        int          best;
        int          slot;
        int unsigned best_gap;
        int unsigned gap;
        t_result     r;
        best     = -1;
        slot     = -1;
        best_gap = 0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (blk_valid[i] && !blk_used[i] && blk_bytes[i] >= req) begin
                gap = blk_bytes[i] - req;
                if (best < 0 || gap < best_gap) begin
                    best     = i;
                    best_gap = gap;
                end
            end
        end
        if (best < 0) begin
            r.payload_offset = '0;
            r.status         = ST_NO_FIT;
            return r;
        end
        blk_used[best] = 1'b1;
        r.status       = ST_DONE;
        // The surplus becomes a new free block only when it can hold a header.
        if (best_gap > HEADER_BYTES) begin
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                if (!blk_valid[i] && slot < 0) begin
                    slot = i;
                end
            end
            if (slot < 0) begin
                r.status = ST_NOSPLIT;
            end else begin
                blk_bytes[best] = req;
                blk_valid[slot] = 1'b1;
                blk_used[slot]  = 1'b0;
                blk_start[slot] = block_end(best);
                blk_bytes[slot] = best_gap - HEADER_BYTES;
            end
        end
        r.payload_offset = OFS_W'(blk_start[best] + HEADER_BYTES);
        return r;
    endfunction

    function automatic t_result predict_free(input int unsigned ofs);
        int      hit;
        bit      merged;
        t_result r;
        r.payload_offset = '0;
        r.status         = ST_IGNORED;
        hit              = -1;
        if (ofs == 0) begin
            return r;
        end
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (hit < 0 && blk_valid[i] && blk_used[i] && blk_start[i] + HEADER_BYTES == ofs) begin
                hit = i;
            end
        end
        if (hit < 0) begin
            return r;
        end
        blk_used[hit] = 1'b0;
        r.status      = ST_DONE;
        // Absorb a free block that starts right after this one.
        merged = 1'b0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (!merged && i != hit && blk_valid[i] && !blk_used[i]
                    && blk_start[i] == block_end(hit)) begin
                blk_bytes[hit] += HEADER_BYTES + blk_bytes[i];
                blk_valid[i]   = 1'b0;
                blk_start[i]   = 0;
                blk_bytes[i]   = 0;
                merged         = 1'b1;
            end
        end
        // Then fold this block into a free block that ends where it starts.
        merged = 1'b0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (!merged && i != hit && blk_valid[i] && !blk_used[i]
                    && block_end(i) == blk_start[hit]) begin
                blk_bytes[i]   += HEADER_BYTES + blk_bytes[hit];
                blk_valid[hit] = 1'b0;
                blk_start[hit] = 0;
                blk_bytes[hit] = 0;
                merged         = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result     want;
        int unsigned wr_val;
        if (!i_rst_n) begin
            pool_bytes = POOL_HIGH;
            init_table();
            grant_expect.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[APB_AW-1:2] == REG_POOL_SIZE) begin
                wr_val = i_pwdata & 32'h0001_FFFF;
                if (wr_val < POOL_LOW) begin
                    wr_val = POOL_LOW;
                end
                if (wr_val > POOL_HIGH) begin
                    wr_val = POOL_HIGH;
                end
                pool_bytes = wr_val;
                init_table();
            end
            // A result beat may share an edge with the next command beat, so the
            // older expectation is consumed before the new one is predicted.
            if (i_valid) begin
                if (grant_expect.size() == 0) begin
                    report($sformatf("result beat offset %0d status %0d with nothing outstanding",
                                     i_result.payload_offset, i_result.status));
                end else begin
                    want = grant_expect.pop_front();
                    if (i_result.payload_offset != want.payload_offset) begin
                        report($sformatf("payload_offset %0d, expected %0d",
                                         i_result.payload_offset, want.payload_offset));
                    end
                    if (i_result.status != want.status) begin
                        report($sformatf("status %0d, expected %0d",
                                         i_result.status, want.status));
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_item.command == CMD_ALLOC) begin
                    grant_expect.push_back(predict_alloc(i_item.request_bytes));
                end else begin
                    grant_expect.push_back(predict_free(i_item.payload_offset_in));
                end
            end
        end
        o_pending = grant_expect.size();
    end

endmodule

// ----- bench/best_fit_block_allocator_unit_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Best-fit allocator testbench
// Drives allocate and free commands and pool size writes into the allocator,
// first a directed set of corner cases, then random segments over several pool
// sizes and idle rates. A checker beside the block predicts every result beat.
// ============================================================================
module best_fit_block_allocator_unit_tb;
    import bfa_pkg::*;

    localparam int SEGMENTS      = 7;
    localparam int SEGMENT_ITEMS = 105;
    localparam logic [APB_AW-1:0] ADDR_POOL  = {REG_POOL_SIZE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SPARE = {~REG_POOL_SIZE, 2'b00};

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                start    = 1'b0;
    logic                busy;
    t_item               cmd_beat = '0;
    logic                o_valid;
    t_result             o_result;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;

    // Offsets granted and not yet released, used to build well-formed frees.
    logic [OFS_W-1:0]    granted [$];

    // Raw pool writes per random segment, with the pool size they settle to.
    logic [31:0] seg_pool [SEGMENTS] = '{32'd65536, 32'd0, 32'd200, 32'd1000,
                                         32'h0001_FFFF, 32'hFFFE_0100, 32'd48};
    int unsigned seg_hint [SEGMENTS] = '{65536, 32, 200, 1000, 65536, 256, 48};
    int          seg_idle [SEGMENTS] = '{0, 61, 22, 0, 61, 22, 0};

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    best_fit_block_allocator_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (cmd_beat),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    best_fit_block_allocator_unit_checker grant_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (cmd_beat),
        .i_valid      (o_valid),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Outputs only move at the rising edge, so the falling edge sees them settled.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && o_result.payload_offset != '0) begin
            granted.push_back(o_result.payload_offset);
        end
    end

    function automatic t_item alloc_beat(input logic [OFS_W-1:0] req);
        t_item it;
        it.command           = CMD_ALLOC;
        it.request_bytes     = req;
        it.payload_offset_in = OFS_W'($urandom);
        return it;
    endfunction

    function automatic t_item free_beat(input logic [OFS_W-1:0] ofs);
        t_item it;
        it.command           = CMD_FREE;
        it.request_bytes     = OFS_W'($urandom);
        it.payload_offset_in = ofs;
        return it;
    endfunction

    function automatic t_item random_command(input int unsigned hint);
        int          pick;
        int unsigned sel;
        t_item       it;
        if ($urandom_range(99) < 55) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                it = alloc_beat(OFS_W'($urandom_range(hint / 6, 0)));
            end else if (pick < 85) begin
                it = alloc_beat(OFS_W'($urandom_range(hint, 0)));
            end else begin
                it = alloc_beat(OFS_W'($urandom));
            end
        end else if (granted.size() != 0 && $urandom_range(99) < 75) begin
            sel = $urandom_range(granted.size() - 1, 0);
            it  = free_beat(granted[sel]);
            granted.delete(sel);
        end else begin
            // Null, unknown, stale or already released offsets.
            case ($urandom_range(3))
                0: it = free_beat('0);
                1: it = free_beat(OFS_W'($urandom));
                2: it = free_beat(OFS_W'(16 * $urandom_range(hint / 16, 1)));
                default: it = free_beat(OFS_W'($urandom_range(hint, 1)));
            endcase
        end
        return it;
    endfunction

    // Called right after a rising edge; returns right after the accepting edge.
    // start stays high so that a following beat can go out back to back.
    task automatic issue(input t_item it);
        start    <= 1'b1;
        cmd_beat <= it;
        @(negedge i_clk);
        while (busy) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic sender_pause(input int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(40, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_pool_reg(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // The bus is left idle before the next transfer, keeping its setup apart from this one.
        @(posedge i_clk);
        granted.delete();
    endtask

    initial begin
        #20_000_000;
        $display("best_fit_block_allocator_unit_tb: FAIL");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full pool after reset: split, no fit, exact fit, ignored frees,
        // double free and a merge back into one block.
        issue(alloc_beat(16'd0));
        issue(alloc_beat(16'hFFFF));
        issue(alloc_beat(16'd65504));
        issue(alloc_beat(16'd0));
        issue(free_beat(16'd0));
        issue(free_beat(16'd16));
        issue(free_beat(16'd16));
        issue(free_beat(16'd40000));
        issue(free_beat(16'd32));
        issue(alloc_beat(16'd65520));
        issue(free_beat(16'd16));
        drain();

        // Below the minimum, saturated up to the smallest pool.
        write_pool_reg(ADDR_POOL, 32'd0);
        issue(alloc_beat(16'd16));
        issue(free_beat(16'd16));
        issue(alloc_beat(16'd0));
        issue(alloc_beat(16'd0));
        issue(free_beat(16'd16));
        drain();

        // One byte of surplus past a header: the split leaves a one-byte block.
        write_pool_reg(ADDR_POOL, 32'd33);
        issue(alloc_beat(16'd0));
        issue(alloc_beat(16'd1));
        issue(free_beat(16'd16));
        issue(free_beat(16'd32));
        drain();

        // Upper bits are dropped and the rest saturates to the largest pool;
        // a write to the unused word leaves the pool alone.
        write_pool_reg(ADDR_POOL, 32'hFFFF_FFFF);
        write_pool_reg(ADDR_SPARE, 32'd64);
        issue(alloc_beat(16'd65520));
        issue(free_beat(16'd16));
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            write_pool_reg(ADDR_POOL, seg_pool[seg]);
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                issue(random_command(seg_hint[seg]));
                sender_pause(seg_idle[seg]);
            end
            drain();
        end

        repeat (64) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("best_fit_block_allocator_unit_tb: PASS");
        end else begin
            $display("best_fit_block_allocator_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
